// ===== hw/rtl/upmix_pkg.sv =====
// Shared types, register indexes, codes and defaults for the stereo upmix block.
package upmix_pkg;

  // Default number of FIR taps per surround channel.
  localparam int unsigned TAPS_DEFAULT = 32;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COEF_IDX_W = 5;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // Output mode codes; any other code gives left and right only.
  localparam logic [MODE_W-1:0] MODE_FULL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SURROUND = 2'd1;

  // Input operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] GAIN_RESET = 32'h7FFF_FFFF;
  localparam logic [THR_W-1:0]    THR_RESET  = 31'h7FFF_FFFF;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_l;
    logic signed [SAMPLE_W-1:0] out_r;
    logic signed [SAMPLE_W-1:0] out_c;
    logic signed [SAMPLE_W-1:0] out_lfe;
    logic signed [SAMPLE_W-1:0] out_ls;
    logic signed [SAMPLE_W-1:0] out_rs;
    logic                       center_valid;
    logic                       surround_valid;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SCALE,
    ST_WRITE,
    ST_FIR,
    ST_DRAIN,
    ST_MIX,
    ST_OUT
  } state_e;

  // Datapath strobes from the sequencer.
  typedef struct packed {
    logic capture;
    logic gain_mul;
    logic scale;
    logic acc_clear;
    logic mac_mul;
    logic mac_acc;
    logic fir_load;
    logic out_load;
  } ctl_t;

endpackage

// ===== hw/rtl/upmix_zmem.sv =====
// Synchronous one-write one-read memory whose entries read as zero until written.
module upmix_zmem #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = upmix_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // One valid bit per entry stands in for clearing the array after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/upmix_dp.sv =====
// Datapath: one multiplier per channel for gain and taps, FIR accumulators, saturation, clamps and output register.
module upmix_dp #(
  parameter int unsigned TAPS = upmix_pkg::TAPS_DEFAULT
) (
  input  logic                                      clk_i,
  input  upmix_pkg::ctl_t                           ctl_i,
  input  upmix_pkg::in_item_t                       in_item_i,
  input  logic signed [upmix_pkg::SAMPLE_W-1:0]     gain_i,
  input  logic [upmix_pkg::MODE_W-1:0]              mode_i,
  input  logic [upmix_pkg::THR_W-1:0]               thr_i,
  input  logic [2*upmix_pkg::SAMPLE_W-1:0]          dly_rdata_i,
  input  logic [upmix_pkg::SAMPLE_W-1:0]            coef_rdata_i,
  output logic [2*upmix_pkg::SAMPLE_W-1:0]          dly_wdata_o,
  output upmix_pkg::out_item_t                      out_item_o
);

  localparam int unsigned SW     = upmix_pkg::SAMPLE_W;
  localparam int unsigned PW     = 2 * SW;
  // Exact sum of TAPS full-precision products.
  localparam int unsigned ACC_W  = PW + 1 + $clog2(TAPS);

  logic signed [SW-1:0]    smp_l_q, smp_r_q;
  logic signed [SW-1:0]    mul_a_l, mul_b_l, mul_a_r, mul_b_r;
  logic signed [PW-1:0]    prod_l_d, prod_r_d;
  logic signed [PW-1:0]    prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0] prod_l_ext, prod_r_ext;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
  logic signed [SW-1:0]    l_q, r_q, ls_q, rs_q;
  logic                    mode_full, mode_sur;
  upmix_pkg::out_item_t    out_d, out_q;

  // Floor to Q1.31, then saturate to the signed 32-bit range.
  function automatic logic signed [SW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-32:0] sh;
    logic signed [SW-1:0]     res;
    sh = v[ACC_W-1:31];
    if ((&sh[ACC_W-32:SW-1]) || (~|sh[ACC_W-32:SW-1])) begin
      res = sh[SW-1:0];
    end else if (sh[ACC_W-32]) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = {1'b0, {(SW-1){1'b1}}};
    end
    return res;
  endfunction

  // Clamp an exact sum of two samples to the symmetric threshold.
  function automatic logic signed [SW-1:0] clamp_thr(input logic signed [SW:0] s,
                                                     input logic [upmix_pkg::THR_W-1:0] thr);
    logic signed [SW:0]   t;
    logic signed [SW:0]   nt;
    logic signed [SW-1:0] res;
    t  = $signed({2'b00, thr});
    nt = -t;
    if (s > t) begin
      res = t[SW-1:0];
    end else if (s < nt) begin
      res = nt[SW-1:0];
    end else begin
      res = s[SW-1:0];
    end
    return res;
  endfunction

  // Each channel owns one multiplier, shared by the gain step and the taps.
  always_comb begin
    if (ctl_i.gain_mul) begin
      mul_a_l = smp_l_q;
      mul_b_l = gain_i;
      mul_a_r = smp_r_q;
      mul_b_r = gain_i;
    end else begin
      mul_a_l = $signed(dly_rdata_i[PW-1:SW]);
      mul_b_l = $signed(coef_rdata_i);
      mul_a_r = $signed(dly_rdata_i[SW-1:0]);
      mul_b_r = $signed(coef_rdata_i);
    end
    prod_l_d = PW'(mul_a_l) * PW'(mul_b_l);
    prod_r_d = PW'(mul_a_r) * PW'(mul_b_r);
  end

  assign prod_l_ext = {{(ACC_W-PW){prod_l_q[PW-1]}}, prod_l_q};
  assign prod_r_ext = {{(ACC_W-PW){prod_r_q[PW-1]}}, prod_r_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      smp_l_q <= $signed(in_item_i.sample_left);
      smp_r_q <= $signed(in_item_i.sample_right);
    end
    if (ctl_i.gain_mul || ctl_i.mac_mul) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    if (ctl_i.scale) begin
      l_q <= sat_acc(prod_l_ext);
      r_q <= sat_acc(prod_r_ext);
    end
    if (ctl_i.acc_clear) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (ctl_i.mac_acc) begin
      acc_l_q <= acc_l_q + prod_l_ext;
      acc_r_q <= acc_r_q + prod_r_ext;
    end
    if (ctl_i.fir_load) begin
      ls_q <= sat_acc(acc_l_q);
      rs_q <= sat_acc(acc_r_q);
    end
    if (ctl_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign mode_full = (mode_i == upmix_pkg::MODE_FULL);
  assign mode_sur  = mode_full || (mode_i == upmix_pkg::MODE_SURROUND);

  always_comb begin
    out_d.out_l          = l_q;
    out_d.out_r          = r_q;
    out_d.out_c          = mode_full ? clamp_thr({l_q[SW-1], l_q} + {r_q[SW-1], r_q}, thr_i)
                                     : '0;
    out_d.out_lfe        = mode_full ? clamp_thr({ls_q[SW-1], ls_q} + {rs_q[SW-1], rs_q}, thr_i)
                                     : '0;
    out_d.out_ls         = mode_sur ? ls_q : '0;
    out_d.out_rs         = mode_sur ? rs_q : '0;
    out_d.center_valid   = mode_full;
    out_d.surround_valid = mode_sur;
  end

  assign dly_wdata_o = {l_q, r_q};
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/upmix_ctrl.sv =====
// Sequencer: handshakes, tap walk over the delay and coefficient memories, write position.
module upmix_ctrl #(
  parameter int unsigned TAPS = upmix_pkg::TAPS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   op_i,
  input  logic [upmix_pkg::COEF_IDX_W-1:0]       coef_index_i,
  input  logic [upmix_pkg::MODE_W-1:0]           mode_i,
  input  logic                                   out_stall_i,
  output logic                                   in_stall_o,
  output logic                                   out_valid_o,
  output upmix_pkg::ctl_t                        ctl_o,
  output logic                                   dly_we_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] dly_waddr_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] dly_raddr_o,
  output logic                                   coef_we_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] coef_waddr_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] coef_raddr_o
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  upmix_pkg::state_e state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     pos_q, pos_d, pos_nxt;
  logic [AW-1:0]     rd_pos_q, rd_pos_d, rd_pos_nxt;
  logic              issue_q, mul_q;
  logic              out_valid_q, out_valid_d;
  logic              out_ready;

  assign pos_nxt    = (pos_q == LAST) ? '0 : pos_q + AW'(1);
  assign rd_pos_nxt = (rd_pos_q == LAST) ? '0 : rd_pos_q + AW'(1);
  assign out_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= upmix_pkg::ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      rd_pos_q    <= '0;
      issue_q     <= 1'b0;
      mul_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      rd_pos_q    <= rd_pos_d;
      issue_q     <= (state_q == upmix_pkg::ST_FIR);
      mul_q       <= issue_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    rd_pos_d  = rd_pos_q;
    ctl_o     = '0;
    dly_we_o  = 1'b0;
    coef_we_o = 1'b0;
    case (state_q)
      upmix_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == upmix_pkg::OP_SAMPLE) begin
            ctl_o.capture = 1'b1;
            state_d       = upmix_pkg::ST_GAIN;
          end else begin
            coef_we_o = (9'(coef_index_i) < 9'(TAPS));
          end
        end
      end
      upmix_pkg::ST_GAIN: begin
        ctl_o.gain_mul = 1'b1;
        state_d        = upmix_pkg::ST_SCALE;
      end
      upmix_pkg::ST_SCALE: begin
        ctl_o.scale = 1'b1;
        if (mode_i == upmix_pkg::MODE_FULL || mode_i == upmix_pkg::MODE_SURROUND) begin
          state_d = upmix_pkg::ST_WRITE;
        end else begin
          state_d = upmix_pkg::ST_OUT;
        end
      end
      upmix_pkg::ST_WRITE: begin
        // Newest sample goes in; the walk starts at the oldest entry just past it.
        dly_we_o        = 1'b1;
        ctl_o.acc_clear = 1'b1;
        pos_d           = pos_nxt;
        rd_pos_d        = pos_nxt;
        cnt_d           = '0;
        state_d         = upmix_pkg::ST_FIR;
      end
      upmix_pkg::ST_FIR: begin
        rd_pos_d = rd_pos_nxt;
        if (cnt_q == LAST) begin
          state_d = upmix_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      upmix_pkg::ST_DRAIN: begin
        if (!issue_q && !mul_q) begin
          state_d = upmix_pkg::ST_MIX;
        end
      end
      upmix_pkg::ST_MIX: begin
        ctl_o.fir_load = 1'b1;
        state_d        = upmix_pkg::ST_OUT;
      end
      upmix_pkg::ST_OUT: begin
        if (out_ready) begin
          ctl_o.out_load = 1'b1;
          state_d        = upmix_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = upmix_pkg::ST_IDLE;
      end
    endcase
    ctl_o.mac_mul = issue_q;
    ctl_o.mac_acc = mul_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o   = (state_q != upmix_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign dly_waddr_o  = pos_q;
  assign dly_raddr_o  = rd_pos_q;
  assign coef_waddr_o = AW'(coef_index_i);
  assign coef_raddr_o = LAST - cnt_q;

`ifndef SYNTH
  a_write_no_reads_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dly_we_o |-> (!issue_q && !mul_q))
    else $error("delay write while tap reads are in flight");

  a_mix_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == upmix_pkg::ST_MIX) |-> (!issue_q && !mul_q && !ctl_o.mac_acc))
    else $error("surround result taken before the accumulator settled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while its transaction is stalled");

  a_coef_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_we_o |-> (state_q == upmix_pkg::ST_IDLE && in_valid_i && op_i == upmix_pkg::OP_COEF))
    else $error("coefficient write outside an accepted coefficient transaction");

  a_fir_walk_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == upmix_pkg::ST_FIR && state_d == upmix_pkg::ST_DRAIN) |-> (coef_raddr_o == '0))
    else $error("tap walk ended before reaching coefficient zero");
`endif

endmodule

// ===== hw/rtl/stereo_upmix_fir_surround_top.sv =====
// Top level of the stereo to 5.1 upmix block with FIR surround channels.
//
// Each sample transaction (op 0) scales the left and right Q1.31 inputs by the gain
// register and returns one result transaction: L and R always; in mode 0 also the
// center (L+R clamped to the threshold), the left and right surrounds (TAPS-tap FIR
// of L and R over circular delay lines) and LFE (Ls+Rs clamped); in mode 1 L, R and
// the surrounds; in other modes only L and R, and the delay lines do not advance.
// Unused output fields read as zero and the two valid flags say which carry data.
// A coefficient transaction (op 1) writes one tap coefficient without leaving idle and
// gives no result; tap 0 multiplies the newest sample, and an index at or beyond
// TAPS is ignored. Products are exact, conversion back to Q1.31 floors and then
// saturates, and the FIR sums all products at full precision before converting once.
// The block works on one sample at a time: it accepts no transaction from the
// acceptance of a sample until that sample's result is loaded into the output register,
// and that load waits while a stalled earlier result still holds the register. In
// mode 0 or 1 the time is set by the one multiply-accumulate unit per channel, which
// walks the delay memory and the coefficient memory one tap per cycle. A finished
// result waits in the output register while the block already takes the next transaction.
// Delay and coefficient memories read as zero after reset without a clearing pass.
// Configuration writes (gain, output mode, threshold) are taken at any cycle with
// cfg_we_i high and must only be issued while the block is idle.
module stereo_upmix_fir_surround_top #(
  parameter int unsigned TAPS = upmix_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  upmix_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output upmix_pkg::out_item_t                out_item_o,
  input  logic                                cfg_we_i,
  input  logic [upmix_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [upmix_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned SW = upmix_pkg::SAMPLE_W;

  logic signed [SW-1:0]            gain_q;
  logic [upmix_pkg::MODE_W-1:0]    mode_q;
  logic [upmix_pkg::THR_W-1:0]     thr_q;

  upmix_pkg::ctl_t                 ctl;
  logic                            dly_we, coef_we;
  logic [AW-1:0]                   dly_waddr, dly_raddr, coef_waddr, coef_raddr;
  logic [2*SW-1:0]                 dly_wdata, dly_rdata;
  logic [SW-1:0]                   coef_rdata;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= upmix_pkg::GAIN_RESET;
      mode_q <= upmix_pkg::MODE_FULL;
      thr_q  <= upmix_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        upmix_pkg::REG_GAIN:      gain_q <= $signed(cfg_wdata_i);
        upmix_pkg::REG_MODE:      mode_q <= cfg_wdata_i[upmix_pkg::MODE_W-1:0];
        upmix_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata_i[upmix_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer owns the handshakes, the write position and the tap walk.
  upmix_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .op_i         (in_item_i.op),
    .coef_index_i (in_item_i.coef_index),
    .mode_i       (mode_q),
    .out_stall_i  (out_stall_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .ctl_o        (ctl),
    .dly_we_o     (dly_we),
    .dly_waddr_o  (dly_waddr),
    .dly_raddr_o  (dly_raddr),
    .coef_we_o    (coef_we),
    .coef_waddr_o (coef_waddr),
    .coef_raddr_o (coef_raddr)
  );

  // Both delay lines share one memory: left in the upper half of each word.
  upmix_zmem #(
    .WIDTH (2 * SW),
    .DEPTH (TAPS)
  ) u_dly_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  upmix_zmem #(
    .WIDTH (SW),
    .DEPTH (TAPS)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_item_i.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Arithmetic and the output register.
  upmix_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .in_item_i    (in_item_i),
    .gain_i       (gain_q),
    .mode_i       (mode_q),
    .thr_i        (thr_q),
    .dly_rdata_i  (dly_rdata),
    .coef_rdata_i (coef_rdata),
    .dly_wdata_o  (dly_wdata),
    .out_item_o   (out_item_o)
  );

endmodule
